### src/rtp_pkg.sv
// Package with the request and response types and shared constants of the region profiler.
package rtp_pkg;

   localparam int SLOTS = 16;
   localparam int SLOT_W = 4;
   localparam int XFER_DEPTH = SLOTS * SLOTS;
   localparam int XFER_AW = 2 * SLOT_W;
   localparam logic [SLOT_W-1:0] UNKNOWN_SLOT = SLOT_W'(SLOTS - 1);

   localparam logic [2:0] CMD_LOAD   = 3'd0;
   localparam logic [2:0] CMD_UNLOAD = 3'd1;
   localparam logic [2:0] CMD_BRANCH = 3'd2;
   localparam logic [2:0] CMD_BLOCK  = 3'd3;
   localparam logic [2:0] CMD_READ   = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [63:0] addr_first;
      logic [63:0] addr_second;
      logic [31:0] region_tag;
      logic [15:0] block_length;
      logic [3:0]  row_index;
      logic [3:0]  col_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  source_region;
      logic [3:0]  target_region;
      logic [31:0] transfer_count;
      logic [63:0] region_instructions;
      logic [63:0] total_instructions;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch request and do lookups
      logic clear_step; // write one zero into the matrix
      logic commit;    // update state and build the response
   } ctl_type;

   typedef struct packed {
      logic clear_done;
   } sts_type;

endpackage

### src/region_transfer_profiler.sv
// Top level of the region transfer profiler.
// After reset the block zeroes all 256 cells of the transfer matrix and
// holds req_stall high meanwhile. Each request then has a capture step, to
// compare the addresses against every region slot in parallel and read the
// matrix RAM, and a commit step, to update the counters and the table and
// load the response register, a split set by the matrix RAM's registered
// read. A new request is taken only when the response register is empty or
// its response leaves at that same edge, so a stalled response holds off the
// next request, and every request yields exactly one response.
module region_transfer_profiler (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rtp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rtp_pkg::rsp_type rsp_data
);
   import rtp_pkg::*;

   ctl_type ctl;
   sts_type sts;

   // The controller sequences the sweep and the capture and commit of each request.
   rtp_controller u_ctl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .sts(sts), .ctl(ctl)
   );

   // The datapath holds all region state and the response register.
   rtp_datapath u_dp (
      .clock(clock), .reset(reset), .req(req_data), .ctl(ctl), .sts(sts),
      .rsp(rsp_data)
   );
endmodule

### src/rtp_ram.sv
// Generic single-port-write RAM with a registered read port.
module rtp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

### src/rtp_datapath.sv
// Datapath: region table, lookups, counters and the transfer matrix.
module rtp_datapath (
   input  logic            clock,
   input  logic            reset,
   input  rtp_pkg::req_type req,
   input  rtp_pkg::ctl_type ctl,
   output rtp_pkg::sts_type sts,
   output rtp_pkg::rsp_type rsp
);
   import rtp_pkg::*;

   logic [63:0] base_ff [SLOTS];
   logic [63:0] end_ff [SLOTS];
   logic [31:0] ident_ff [SLOTS];
   logic [SLOTS-1:0] loaded_ff;
   logic [SLOT_W:0] used_ff;
   logic [63:0] cnt_ff [SLOTS];
   logic [63:0] total_ff;
   logic [XFER_AW-1:0] clr_ff;

   req_type req_ff;
   logic [SLOT_W-1:0] src_ff, dst_ff, match_ff;
   logic match_hit_ff;
   rsp_type rsp_ff, rsp_in;

   // Combinational lookups on the incoming request.
   logic [SLOTS-1:0] in_a, in_b, same;
   logic [SLOT_W-1:0] src_in, dst_in, match_in;
   logic match_hit_in;
   logic want_loaded;

   always_comb begin
      want_loaded = (req.cmd == CMD_UNLOAD);
      for (int i = 0; i < SLOTS; i++) begin
         logic act;
         act = (SLOT_W+1)'(i) < used_ff;
         in_a[i] = act && loaded_ff[i] && base_ff[i] <= req.addr_first
                   && end_ff[i] > req.addr_first;
         in_b[i] = act && loaded_ff[i] && base_ff[i] <= req.addr_second
                   && end_ff[i] > req.addr_second;
         same[i] = act && (loaded_ff[i] == want_loaded) && base_ff[i] == req.addr_first
                   && end_ff[i] == req.addr_second && ident_ff[i] == req.region_tag;
      end
      src_in = UNKNOWN_SLOT;
      dst_in = UNKNOWN_SLOT;
      match_in = '0;
      match_hit_in = 1'b0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (in_a[i]) src_in = SLOT_W'(i);
         if (in_b[i]) dst_in = SLOT_W'(i);
         if (same[i]) begin
            match_in = SLOT_W'(i);
            match_hit_in = 1'b1;
         end
      end
      // The target keeps the source slot whenever it also lies in it.
      if (src_in != UNKNOWN_SLOT && in_b[src_in]) dst_in = src_in;
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         req_ff <= req;
         src_ff <= src_in;
         dst_ff <= dst_in;
         match_ff <= match_in;
         match_hit_ff <= match_hit_in;
      end
   end

   // Transfer matrix; a read port fetches either the branch cell or the read cell.
   logic xf_we;
   logic [XFER_AW-1:0] xf_waddr, xf_raddr;
   logic [31:0] xf_wdata, xf_rdata;
   assign xf_raddr = (req.cmd == CMD_READ) ? {req.row_index, req.col_index}
                                           : {src_in, dst_in};
   assign xf_we = ctl.clear_step || (ctl.commit && req_ff.cmd == CMD_BRANCH);
   assign xf_waddr = ctl.clear_step ? clr_ff : {src_ff, dst_ff};
   assign xf_wdata = ctl.clear_step ? 32'd0 : xf_rdata + 32'd1;
   assign sts.clear_done = (clr_ff == XFER_AW'(XFER_DEPTH - 1));

   rtp_ram #(.WIDTH(32), .DEPTH(XFER_DEPTH)) u_xfer (
      .clock(clock), .wr_en(xf_we), .wr_addr(xf_waddr), .wr_data(xf_wdata),
      .rd_addr(xf_raddr), .rd_data(xf_rdata)
   );

   logic full;
   assign full = used_ff >= (SLOT_W+1)'(SLOTS - 1);
   logic [63:0] total_next;
   assign total_next = (req_ff.cmd == CMD_BLOCK) ? total_ff + 64'(req_ff.block_length)
                                                 : total_ff;

   // Response built from the captured request and the current table state.
   always_comb begin
      rsp_in = '0;
      rsp_in.total_instructions = total_next;
      case (req_ff.cmd)
         CMD_LOAD: begin
            if (match_hit_ff) rsp_in.source_region = match_ff;
            else if (!full) rsp_in.source_region = used_ff[SLOT_W-1:0];
            else rsp_in.status = ST_FULL;
         end
         CMD_UNLOAD: begin
            if (match_hit_ff) rsp_in.source_region = match_ff;
            else rsp_in.status = ST_NOTFOUND;
         end
         CMD_BRANCH: begin
            rsp_in.source_region = src_ff;
            rsp_in.target_region = dst_ff;
         end
         CMD_BLOCK: begin
            rsp_in.source_region = src_ff;
         end
         CMD_READ: begin
            rsp_in.transfer_count = xf_rdata;
            rsp_in.region_instructions = cnt_ff[req_ff.row_index];
         end
         default: ;
      endcase
   end

   assign rsp = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= '0;
         used_ff <= '0;
         total_ff <= '0;
         clr_ff <= '0;
         for (int i = 0; i < SLOTS; i++) cnt_ff[i] <= '0;
      end else begin
         if (ctl.clear_step) clr_ff <= clr_ff + XFER_AW'(1);
         if (ctl.commit) begin
            total_ff <= total_next;
            rsp_ff <= rsp_in;
            case (req_ff.cmd)
               CMD_LOAD: begin
                  if (match_hit_ff) begin
                     loaded_ff[match_ff] <= 1'b1;
                  end else if (!full) begin
                     base_ff[used_ff[SLOT_W-1:0]] <= req_ff.addr_first;
                     end_ff[used_ff[SLOT_W-1:0]] <= req_ff.addr_second;
                     ident_ff[used_ff[SLOT_W-1:0]] <= req_ff.region_tag;
                     loaded_ff[used_ff[SLOT_W-1:0]] <= 1'b1;
                     used_ff <= used_ff + (SLOT_W+1)'(1);
                  end
               end
               CMD_UNLOAD: begin
                  if (match_hit_ff) loaded_ff[match_ff] <= 1'b0;
               end
               CMD_BLOCK: begin
                  cnt_ff[src_ff] <= cnt_ff[src_ff] + 64'(req_ff.block_length);
               end
               default: ;
            endcase
         end
      end
   end

   stage_total: assert property (@(posedge clock) disable iff (reset)
      ctl.commit && req_ff.cmd != CMD_BLOCK |=> $stable(total_ff))
      else $error("total changed on a non-block command");
   used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= (SLOT_W+1)'(SLOTS - 1))
      else $error("slot count exceeds table");
   one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.capture, ctl.clear_step, ctl.commit}))
      else $error("controller issued overlapping commands");
endmodule

### src/rtp_controller.sv
// Controller: clearing sweep after reset, then capture and commit of each request.
module rtp_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  rtp_pkg::sts_type sts,
   output rtp_pkg::ctl_type ctl
);
   import rtp_pkg::*;

   typedef enum logic [1:0] {CLEAR, IDLE, WORK} state_type;
   state_type state_ff;
   logic rsp_valid_ff;

   // A request may enter when idle and the result register is free or leaving.
   logic take;
   assign take = (state_ff == IDLE) && req_valid && !req_stall;
   assign req_stall = (state_ff != IDLE) || (rsp_valid_ff && rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign ctl.capture = take;
   assign ctl.clear_step = (state_ff == CLEAR);
   assign ctl.commit = (state_ff == WORK);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (state_ff)
            CLEAR: if (sts.clear_done) state_ff <= IDLE;
            IDLE:  if (take) state_ff <= WORK;
            WORK: begin
               state_ff <= IDLE;
               rsp_valid_ff <= 1'b1;
            end
            default: state_ff <= CLEAR;
         endcase
      end
   end

   no_take_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.commit |-> !(rsp_valid_ff && rsp_stall))
      else $error("commit would overwrite a waiting result");
   work_follows: assert property (@(posedge clock) disable iff (reset)
      take |=> state_ff == WORK)
      else $error("accepted request did not start");
   rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      state_ff == WORK |=> rsp_valid_ff)
      else $error("finished request produced no result");
endmodule
